/* hdl/race_label_encoder_core_defines.svh */
// Assertion macros for the label encoder.
`ifndef RACE_LABEL_ENCODER_CORE_DEFINES_SVH
`define RACE_LABEL_ENCODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RLE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RLE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/rle_pkg.sv */
`default_nettype none
package rle_pkg;
  localparam int unsigned OctetDepth = 36;
  localparam logic [7:0] FullModeU1 = 8'hD8;
  localparam logic [7:0] ReservedLo = 8'hD8;
  localparam logic [7:0] ReservedHi = 8'hDC;
  localparam logic [7:0] EscOctet = 8'hFF;
  localparam logic [7:0] FfMark = 8'h99;
  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatLong = 2'd1;
  localparam logic [1:0] StatReserved = 2'd2;
  localparam logic [1:0] StatForbidden = 2'd3;

  typedef enum logic [3:0] {
    S_COLLECT, S_SCAN_RD, S_SCAN, S_BUILD_RD, S_BUILD, S_BUILD_FF,
    S_CHECK, S_PREFIX, S_B32_RD, S_B32, S_ERROR
  } state_t;

  function automatic logic [7:0] b32_char(input logic [4:0] v);
    if (v < 5'd26) return 8'h61 + {3'b000, v};
    else return 8'h32 + {3'b000, v - 5'd26};
  endfunction

  function automatic logic [7:0] prefix_char(input logic [1:0] i);
    case (i)
      2'd0: return 8'h62;
      2'd1: return 8'h71;
      default: return 8'h2D;
    endcase
  endfunction
endpackage
`default_nettype wire

/* hdl/rle_stream_if.sv */
`default_nettype none
interface rle_stream_if #(parameter int unsigned W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/race_label_encoder_core.sv */
// Label units are taken one per cycle while collecting, with no result.
// After the last unit, modes one and two scan the label (S_SCAN_RD, S_SCAN);
// then octets are built (S_BUILD_RD, S_BUILD, S_BUILD_FF) and the length checked.
// bq-- and base32 text leave one character per cycle unless the output stalls,
// with an octet read state at the start and at each octet boundary; an error
// gives a single beat instead. Reset restores the label state and a limit of 36.
`default_nettype none
`include "race_label_encoder_core_defines.svh"
module race_label_encoder_core #(
  parameter int unsigned MAX_UNITS = 64
) (
  input wire logic clk,
  input wire logic rst_n,
  rle_stream_if.sink   in_if,
  rle_stream_if.source out_if,
  rle_stream_if.sink   cfg_if
);
  import rle_pkg::*;
  localparam int unsigned AW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int unsigned CW = $clog2(MAX_UNITS + 1);
  localparam int unsigned OW = $clog2(OctetDepth);

  state_t state_r, state_nxt;
  logic [5:0] limit_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0] first_r, first_nxt, other_r, other_nxt;
  logic same_r, same_nxt, two_r, two_nxt, ovf_r, ovf_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [6:0] oc_r, oc_nxt;
  logic [7:0] u1_r, u1_nxt;
  logic full_r, full_nxt, hi_r, hi_nxt;
  logic [8:0] bit_r, bit_nxt;
  logic [1:0] pre_r, pre_nxt, err_r, err_nxt;
  logic [7:0] ochar_r, ochar_nxt;
  logic [1:0] ostat_r, ostat_nxt;
  logic olast_r, olast_nxt, ovalid_r, ovalid_nxt;

  logic u_we, o_we;
  logic [AW-1:0] u_waddr, u_raddr;
  logic [15:0] u_rdata;
  logic [OW-1:0] o_waddr, o_raddr;
  logic [7:0] o_wdata, o_rdata, o_rdata_next;
  logic [OW-1:0] o_raddr_r, o_raddr_r_nxt;
  logic [15:0] cu;
  logic [7:0] up, uhi, ulo;
  logic [9:0] bits_tot;
  logic [5:0] lim;
  logic [15:0] win;
  logic [4:0] b32v;
  logic [2:0] boff;
  logic out_free;

  assign cu = in_if.data[16:1];
  assign up = cu[15:8];
  assign uhi = u_rdata[15:8];
  assign ulo = u_rdata[7:0];
  assign out_free = !ovalid_r || out_if.ready;
  assign cfg_if.ready = 1'b1;
  assign in_if.ready = (state_r == S_COLLECT);
  assign out_if.valid = ovalid_r;
  assign out_if.data = {ochar_r, ostat_r, olast_r};
  assign lim = (limit_r > 6'd36) ? 6'd36 : limit_r;
  assign bits_tot = {oc_r, 3'b000};

  rle_ram #(.WIDTH(16), .DEPTH(MAX_UNITS)) u_units (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(cu), .raddr(u_raddr), .rdata(u_rdata)
  );
  rle_ram #(.WIDTH(8), .DEPTH(OctetDepth)) u_octets (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata), .raddr(o_raddr),
    .rdata(o_rdata)
  );

  // First octet for the base32 window: held in prev_r; the second is the octet read.
  logic [7:0] prev_r, prev_nxt;
  assign o_rdata_next = ({1'b0, o_raddr_r} >= oc_r[OW:0]) ? 8'h00 : o_rdata;
  assign boff = bit_r[2:0];
  assign win = {prev_r, o_rdata_next};
  assign b32v = 5'(win >> (5'd11 - {2'b00, boff}));

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r; first_nxt = first_r; other_nxt = other_r;
    same_nxt = same_r; two_nxt = two_r; ovf_nxt = ovf_r;
    idx_nxt = idx_r; oc_nxt = oc_r; u1_nxt = u1_r; full_nxt = full_r; hi_nxt = hi_r;
    bit_nxt = bit_r; pre_nxt = pre_r; err_nxt = err_r; prev_nxt = prev_r;
    ochar_nxt = ochar_r; ostat_nxt = ostat_r; olast_nxt = olast_r;
    ovalid_nxt = ovalid_r && !out_if.ready;
    u_we = 1'b0; u_waddr = count_r[AW-1:0]; u_raddr = idx_r;
    o_we = 1'b0; o_waddr = oc_r[OW-1:0]; o_wdata = 8'h00; o_raddr = o_raddr_r;
    o_raddr_r_nxt = o_raddr_r;
    case (state_r)
      S_COLLECT: begin
        if (in_if.valid) begin
          if (count_r == '0) first_nxt = up;
          else if (up != first_r) same_nxt = 1'b0;
          if (up != 8'h00) begin
            if (other_r == 8'h00) other_nxt = up;
            else if (up != other_r) two_nxt = 1'b0;
          end
          if (count_r < CW'(MAX_UNITS)) begin
            u_we = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_if.data[0]) begin
            idx_nxt = '0;
            if (ovf_nxt) begin
              err_nxt = StatLong; state_nxt = S_ERROR;
            end else if (same_nxt) begin
              u1_nxt = first_nxt; full_nxt = 1'b0;
            end else if (two_nxt) begin
              u1_nxt = other_nxt; full_nxt = 1'b0;
            end else begin
              u1_nxt = FullModeU1; full_nxt = 1'b1;
            end
            if (!ovf_nxt) begin
              if (same_nxt || two_nxt) begin
                if ((same_nxt ? first_nxt : other_nxt) >= ReservedLo &&
                    (same_nxt ? first_nxt : other_nxt) <= ReservedHi) begin
                  err_nxt = StatReserved; state_nxt = S_ERROR;
                end else begin
                  state_nxt = S_SCAN_RD;
                end
              end else begin
                state_nxt = S_BUILD_RD;
              end
            end
            oc_nxt = 7'd1;
          end
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (u_rdata == 16'h0099) begin
          err_nxt = StatForbidden; state_nxt = S_ERROR;
        end else if (CW'(idx_r) == CW'(count_r - 1'b1)) begin
          idx_nxt = '0; state_nxt = S_BUILD_RD;
        end else begin
          idx_nxt = idx_r + 1'b1; state_nxt = S_SCAN_RD;
        end
      end
      S_BUILD_RD: begin
        // Octet slot zero holds U1.
        o_we = 1'b1; o_waddr = '0; o_wdata = u1_r;
        hi_nxt = 1'b1;
        state_nxt = S_BUILD;
      end
      S_BUILD: begin
        if (oc_r < 7'(OctetDepth)) o_we = 1'b1;
        oc_nxt = (oc_r > 7'(OctetDepth)) ? oc_r : oc_r + 1'b1;
        if (full_r) o_wdata = hi_r ? uhi : ulo;
        else if (uhi == u1_r) o_wdata = ulo;
        else o_wdata = EscOctet;
        if ((full_r && !hi_r) || (!full_r && uhi == u1_r && ulo != EscOctet)) begin
          hi_nxt = 1'b1;
          if (CW'(idx_r) == CW'(count_r - 1'b1)) state_nxt = S_CHECK;
          else begin
            idx_nxt = idx_r + 1'b1; state_nxt = S_BUILD_RD;
            if (full_r) state_nxt = S_BUILD_FF;
          end
        end else if (full_r) begin
          hi_nxt = 1'b0;
        end else begin
          state_nxt = S_BUILD_FF;
          hi_nxt = 1'b0;
        end
      end
      S_BUILD_FF: begin
        if (hi_r) begin
          state_nxt = S_BUILD;
        end else begin
          if (oc_r < 7'(OctetDepth)) o_we = 1'b1;
          oc_nxt = (oc_r > 7'(OctetDepth)) ? oc_r : oc_r + 1'b1;
          o_wdata = (uhi == u1_r) ? FfMark : ulo;
          hi_nxt = 1'b1;
          if (CW'(idx_r) == CW'(count_r - 1'b1)) state_nxt = S_CHECK;
          else begin
            idx_nxt = idx_r + 1'b1; state_nxt = S_BUILD_RD;
          end
        end
      end
      S_CHECK: begin
        if (oc_r > {1'b0, lim}) begin
          err_nxt = StatLong; state_nxt = S_ERROR;
        end else begin
          pre_nxt = 2'd0; state_nxt = S_PREFIX;
        end
      end
      S_PREFIX: begin
        o_raddr = '0;
        if (out_free) begin
          ovalid_nxt = 1'b1; ochar_nxt = prefix_char(pre_r);
          ostat_nxt = StatOk; olast_nxt = 1'b0;
          pre_nxt = pre_r + 1'b1;
          if (pre_r == 2'd3) begin
            bit_nxt = '0; o_raddr_r_nxt = '0; state_nxt = S_B32_RD;
          end
        end
      end
      S_B32_RD: begin
        prev_nxt = o_rdata;
        o_raddr_r_nxt = o_raddr_r + 1'b1;
        o_raddr = o_raddr_r + 1'b1;
        state_nxt = S_B32;
      end
      S_B32: begin
        o_raddr = o_raddr_r;
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ochar_nxt = b32_char(b32v);
          ostat_nxt = StatOk;
          bit_nxt = bit_r + 9'd5;
          olast_nxt = ({1'b0, bit_r} + 10'd5 >= bits_tot);
          if ({1'b0, bit_r} + 10'd5 >= bits_tot) begin
            state_nxt = S_COLLECT;
            count_nxt = '0; first_nxt = '0; other_nxt = '0;
            same_nxt = 1'b1; two_nxt = 1'b1; ovf_nxt = 1'b0;
          end else if ({1'b0, boff} + 4'd5 >= 4'd8) begin
            prev_nxt = o_rdata;
            state_nxt = S_B32_RD;
            o_raddr_r_nxt = o_raddr_r;
          end
        end
      end
      S_ERROR: begin
        if (out_free) begin
          ovalid_nxt = 1'b1; ochar_nxt = 8'h00; ostat_nxt = err_r; olast_nxt = 1'b1;
          state_nxt = S_COLLECT;
          count_nxt = '0; first_nxt = '0; other_nxt = '0;
          same_nxt = 1'b1; two_nxt = 1'b1; ovf_nxt = 1'b0;
        end
      end
      default: state_nxt = S_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_COLLECT; limit_r <= 6'd36; count_r <= '0;
      first_r <= '0; other_r <= '0; same_r <= 1'b1; two_r <= 1'b1; ovf_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_if.valid) limit_r <= cfg_if.data[5:0];
      count_r <= count_nxt; first_r <= first_nxt; other_r <= other_nxt;
      same_r <= same_nxt; two_r <= two_nxt; ovf_r <= ovf_nxt;
      ovalid_r <= ovalid_nxt;
    end
    idx_r <= idx_nxt; oc_r <= oc_nxt; u1_r <= u1_nxt; full_r <= full_nxt;
    hi_r <= hi_nxt; bit_r <= bit_nxt; pre_r <= pre_nxt; err_r <= err_nxt;
    prev_r <= prev_nxt; o_raddr_r <= o_raddr_r_nxt;
    ochar_r <= ochar_nxt; ostat_r <= ostat_nxt; olast_r <= olast_nxt;
  end

  `RLE_ASSERT_IMPL(a_no_in_busy, clk, rst_n, state_r != S_COLLECT, !in_if.ready)
  `RLE_ASSERT_NEXT(a_err_last, clk, rst_n, state_r == S_ERROR && out_free, olast_r)
  `RLE_ASSERT_IMPL(a_count_max, clk, rst_n, 1'b1, count_r <= CW'(MAX_UNITS))
endmodule
`default_nettype wire

/* hdl/rle_ram.sv */
`default_nettype none
module rle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [AW-1:0]      waddr,
  input  wire logic [WIDTH-1:0]   wdata,
  input  wire logic [AW-1:0]      raddr,
  output logic      [WIDTH-1:0]   rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* tb/race_label_encoder_core_tb.sv */
`default_nettype none
module race_label_encoder_core_tb;
  import rle_pkg::*;

  localparam int unsigned MaxUnits = 64;
  localparam int unsigned CycleLimit = 300000;

  typedef struct packed {
    logic [7:0] ch;
    logic [1:0] status;
    logic       last;
  } enc_char_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rle_stream_if #(.W(17)) in_if ();
  rle_stream_if #(.W(11)) out_if ();
  rle_stream_if #(.W(6))  cfg_if ();

  race_label_encoder_core #(.MAX_UNITS(MaxUnits)) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [16:0]  pending_units[$];
  enc_char_t    expected_chars[$];
  logic [15:0]  label_units[$];
  int unsigned  octet_limit_now = 36;
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;
  bit           bursts_on = 1'b1;
  bit           long_hold_go = 1'b0;
  bit           long_hold_done = 1'b0;
  int unsigned  long_hold_left = 0;
  int unsigned  src_gap = 0;
  int unsigned  sink_gap = 0;

  function automatic void push_char(logic [7:0] c, logic [1:0] st, logic lst);
    enc_char_t e;
    e.ch = c;
    e.status = st;
    e.last = lst;
    expected_chars.push_back(e);
  endfunction

  function automatic logic [7:0] base32_of(logic [4:0] v);
    if (v < 5'd26) return 8'h61 + {3'b000, v};
    return 8'h32 + {3'b000, v} - 8'd26;
  endfunction

  // Encodes the collected label and queues the characters it should produce.
  function automatic void encode_label();
    logic [7:0] u1;
    logic [7:0] first_up;
    logic [7:0] other_up;
    logic [7:0] up;
    logic [7:0] lo;
    logic [7:0] octs[$];
    logic [4:0] v;
    bit same;
    bit two;
    bit forbidden;
    int unsigned lim;
    int unsigned nbits;
    int unsigned nch;
    int unsigned q;
    same = 1'b1;
    two = 1'b1;
    forbidden = 1'b0;
    other_up = 8'h00;
    first_up = label_units[0][15:8];
    foreach (label_units[i]) begin
      up = label_units[i][15:8];
      if (up != first_up) same = 1'b0;
      if (up != 8'h00) begin
        if (other_up == 8'h00) other_up = up;
        else if (up != other_up) two = 1'b0;
      end
      if (label_units[i] == {8'h00, FfMark}) forbidden = 1'b1;
    end
    if (label_units.size() > MaxUnits) begin
      push_char(8'h00, StatLong, 1'b1);
    end else begin
      u1 = same ? first_up : (two ? other_up : FullModeU1);
      octs.push_back(u1);
      if (!same && !two) begin
        foreach (label_units[i]) begin
          octs.push_back(label_units[i][15:8]);
          octs.push_back(label_units[i][7:0]);
        end
      end else begin
        foreach (label_units[i]) begin
          up = label_units[i][15:8];
          lo = label_units[i][7:0];
          if (up == u1 && lo != EscOctet) begin
            octs.push_back(lo);
          end else if (up == u1) begin
            octs.push_back(EscOctet);
            octs.push_back(FfMark);
          end else begin
            octs.push_back(EscOctet);
            octs.push_back(lo);
          end
        end
      end
      lim = (octet_limit_now > OctetDepth) ? OctetDepth : octet_limit_now;
      if ((same || two) && u1 >= ReservedLo && u1 <= ReservedHi) begin
        push_char(8'h00, StatReserved, 1'b1);
      end else if ((same || two) && forbidden) begin
        push_char(8'h00, StatForbidden, 1'b1);
      end else if (octs.size() > lim) begin
        push_char(8'h00, StatLong, 1'b1);
      end else begin
        push_char("b", StatOk, 1'b0);
        push_char("q", StatOk, 1'b0);
        push_char("-", StatOk, 1'b0);
        push_char("-", StatOk, 1'b0);
        nbits = octs.size() * 8;
        nch = (nbits + 4) / 5;
        for (int c = 0; c < nch; c++) begin
          for (int b = 0; b < 5; b++) begin
            q = c * 5 + b;
            v[4 - b] = (q < nbits) ? octs[q / 8][7 - (q % 8)] : 1'b0;
          end
          push_char(base32_of(v), StatOk, c == nch - 1);
        end
      end
    end
    label_units.delete();
  endfunction

  // Sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!(in_if.valid && !in_if.ready)) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_if.valid <= 1'b0;
      end else if (pending_units.size() > 0) begin
        in_if.data <= pending_units.pop_front();
        in_if.valid <= 1'b1;
        if (bursts_on && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 16);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Accepted code units feed the encoder model.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      label_units.push_back(in_if.data[16:1]);
      if (in_if.data[0]) encode_label();
    end
  end

  // Receiver, with random stall bursts and one long hold.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (long_hold_go && !long_hold_done) begin
      long_hold_done <= 1'b1;
      long_hold_left <= 400;
      out_if.ready <= 1'b0;
    end else if (long_hold_left > 0) begin
      long_hold_left <= long_hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (bursts_on && $urandom_range(0, 9) == 0) sink_gap <= $urandom_range(1, 16);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    enc_char_t got;
    enc_char_t exp_c;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %h", got);
      end else begin
        exp_c = expected_chars.pop_front();
        if (got != exp_c) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected char %h status %0d last %0b, got char %h status %0d last %0b",
                     exp_c.ch, exp_c.status, exp_c.last, got.ch, got.status, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("race_label_encoder_core_tb: done, errors");
      $finish;
    end
  end

  task automatic queue_label(input logic [15:0] units[$]);
    foreach (units[i]) pending_units.push_back({units[i], i == units.size() - 1});
  endtask

  task automatic drain();
    while (pending_units.size() > 0 || in_if.valid || expected_chars.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_limit(input logic [5:0] lim);
    cfg_if.data <= lim;
    cfg_if.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    octet_limit_now = lim;
  endtask

  function automatic logic [15:0] rand_low(input logic [7:0] up);
    case ($urandom_range(0, 9))
      0: return {up, EscOctet};
      1: return {up, FfMark};
      default: return {up, 8'($urandom)};
    endcase
  endfunction

  task automatic random_label(input int unsigned n);
    logic [15:0] units[$];
    logic [7:0] up;
    int unsigned mode;
    mode = $urandom_range(0, 3);
    up = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom);
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: units.push_back(rand_low(up));
        1: units.push_back(rand_low($urandom_range(0, 1) ? up : 8'h00));
        default: units.push_back(16'($urandom));
      endcase
    end
    queue_label(units);
  endtask

  task automatic random_phase(input int unsigned items);
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 34) : $urandom_range(1, 10);
      random_label(n);
      sent += n;
    end
  endtask

  initial begin
    logic [15:0] lbl[$];
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    lbl = '{16'h0000};                          queue_label(lbl);
    lbl = '{16'hFFFF};                          queue_label(lbl);
    lbl = '{16'h0061, 16'h0062, 16'h00FF};      queue_label(lbl);
    lbl = '{16'h0141, 16'h01FF, 16'h0061};      queue_label(lbl);
    lbl = '{16'h0061, 16'h0099};                queue_label(lbl);
    lbl = '{16'hD800, 16'hD8FF};                queue_label(lbl);
    lbl = '{16'hDC12, 16'h0030};                queue_label(lbl);
    lbl = '{16'h1234, 16'h5678, 16'h0099};      queue_label(lbl);
    drain();
    lbl.delete();
    for (int i = 0; i < MaxUnits + 2; i++) lbl.push_back(16'h0041);
    queue_label(lbl);
    lbl = '{16'h0341, 16'h0342, 16'h0343};
    queue_label(lbl);
    drain();

    write_limit(6'd1);
    lbl = '{16'h0041};                          queue_label(lbl);
    lbl = '{16'h0000, 16'h0001};                queue_label(lbl);
    random_phase(8);
    drain();

    write_limit(6'd12);
    long_hold_go = 1'b1;
    random_phase(14);
    drain();

    write_limit(6'd63);
    random_phase(8);
    drain();

    write_limit(6'd36);
    bursts_on = 1'b0;
    random_phase(8);
    drain();

    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("race_label_encoder_core_tb: done, clean");
    end else begin
      $display("race_label_encoder_core_tb: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
+incdir+hdl
hdl/rle_pkg.sv
hdl/rle_stream_if.sv
hdl/rle_ram.sv
hdl/race_label_encoder_core.sv
tb/race_label_encoder_core_tb.sv
